[rtl/scae_pkg.sv]
// Shared types, widths, latencies and coefficient tables for the strong coupling evaluator.
// Used by every module under rtl except scae_delay; depends on nothing else.
`default_nettype none
package scae_pkg;

  localparam int Q2_W      = 48;
  localparam int LAM_W     = 24;
  localparam int ORD_W     = 2;
  localparam int NF_W      = 3;
  localparam int ALPHA_W   = 32;
  localparam int LR_W      = 38;  // L in Q.32 stays below 2^38
  localparam int LOG_ITER  = 32;  // fraction bits of each logarithm
  localparam int LOG_LAT   = 2 + 2 * LOG_ITER;
  localparam int DIV_STEPS = 65;
  localparam int LN2_LAT   = 2;
  localparam int SMUL_LAT  = 2;

  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AC;
  localparam logic [63:0] PI_Q56  = 64'h0324_3F6A_8885_A309;
  localparam logic [63:0] SAT_LIM = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] HALF_Q32 = 64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] LOG_BIAS = 64'sh0000_0020_0000_0000;

  localparam logic [Q2_W-1:0] NF3_MIN = 48'd656;
  localparam logic [Q2_W-1:0] NF4_MIN = 48'd109059;
  localparam logic [Q2_W-1:0] NF5_MIN = 48'd1101661;
  localparam logic [Q2_W-1:0] NF6_MIN = 48'd1938817024;

  localparam logic [LAM_W-1:0] LAMBDA_RST = 24'd26214;
  localparam logic [ORD_W-1:0] ORDER_RST  = 2'd2;

  typedef enum logic [0:0] {
    REG_LAMBDA_SQ = 1'b0,
    REG_EXP_ORDER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [NF_W-1:0]  nf;
    logic             dom;
    logic [ORD_W-1:0] ord;
  } side_t;

  // Leading coefficient 4pi/b0 in Q.32.
  localparam logic [63:0] PI12 = 64'd12 * PI_Q56;
  localparam logic [63:0] A_NF2 = (PI12 / 64'd29) >> 24;
  localparam logic [63:0] A_NF3 = (PI12 / 64'd27) >> 24;
  localparam logic [63:0] A_NF4 = (PI12 / 64'd25) >> 24;
  localparam logic [63:0] A_NF5 = (PI12 / 64'd23) >> 24;
  localparam logic [63:0] A_NF6 = (PI12 / 64'd21) >> 24;

  // c1 = 2 b1 / b0^2 in Q.32.
  localparam logic [63:0] C1_NF2 = (64'd690 << 32) / 64'd841;
  localparam logic [63:0] C1_NF3 = (64'd576 << 32) / 64'd729;
  localparam logic [63:0] C1_NF4 = (64'd462 << 32) / 64'd625;
  localparam logic [63:0] C1_NF5 = (64'd348 << 32) / 64'd529;
  localparam logic [63:0] C1_NF6 = (64'd234 << 32) / 64'd441;

  // c1 squared, truncated to Q.32; c1 stays below 2^32 so no saturation occurs.
  localparam logic [63:0] CC_NF2 = (C1_NF2 * C1_NF2) >> 32;
  localparam logic [63:0] CC_NF3 = (C1_NF3 * C1_NF3) >> 32;
  localparam logic [63:0] CC_NF4 = (C1_NF4 * C1_NF4) >> 32;
  localparam logic [63:0] CC_NF5 = (C1_NF5 * C1_NF5) >> 32;
  localparam logic [63:0] CC_NF6 = (C1_NF6 * C1_NF6) >> 32;

  // d = b2 b0 / (8 b1^2) - 5/4 in Q.32, quotient truncated toward zero.
  localparam logic signed [63:0] D_NF2 =
    (64'sd1398989 * 64'sd4294967296) / 64'sd952200 - 64'sd5368709120;
  localparam logic signed [63:0] D_NF3 =
    (64'sd938709 * 64'sd4294967296) / 64'sd663552 - 64'sd5368709120;
  localparam logic signed [63:0] D_NF4 =
    (64'sd548575 * 64'sd4294967296) / 64'sd426888 - 64'sd5368709120;
  localparam logic signed [63:0] D_NF5 =
    (64'sd224687 * 64'sd4294967296) / 64'sd242208 - 64'sd5368709120;
  localparam logic signed [63:0] D_NF6 =
    (-64'sd36855 * 64'sd4294967296) / 64'sd109512 - 64'sd5368709120;

  function automatic logic signed [63:0] coef_a(input logic [NF_W-1:0] nf);
    case (nf)
      3'd2:    coef_a = $signed(A_NF2);
      3'd3:    coef_a = $signed(A_NF3);
      3'd4:    coef_a = $signed(A_NF4);
      3'd5:    coef_a = $signed(A_NF5);
      default: coef_a = $signed(A_NF6);
    endcase
  endfunction

  function automatic logic signed [63:0] coef_c1(input logic [NF_W-1:0] nf);
    case (nf)
      3'd2:    coef_c1 = $signed(C1_NF2);
      3'd3:    coef_c1 = $signed(C1_NF3);
      3'd4:    coef_c1 = $signed(C1_NF4);
      3'd5:    coef_c1 = $signed(C1_NF5);
      default: coef_c1 = $signed(C1_NF6);
    endcase
  endfunction

  function automatic logic signed [63:0] coef_cc(input logic [NF_W-1:0] nf);
    case (nf)
      3'd2:    coef_cc = $signed(CC_NF2);
      3'd3:    coef_cc = $signed(CC_NF3);
      3'd4:    coef_cc = $signed(CC_NF4);
      3'd5:    coef_cc = $signed(CC_NF5);
      default: coef_cc = $signed(CC_NF6);
    endcase
  endfunction

  function automatic logic signed [63:0] coef_d(input logic [NF_W-1:0] nf);
    case (nf)
      3'd2:    coef_d = D_NF2;
      3'd3:    coef_d = D_NF3;
      3'd4:    coef_d = D_NF4;
      3'd5:    coef_d = D_NF5;
      default: coef_d = D_NF6;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/scae_delay.sv]
// Enabled shift line that keeps side data and valid bits aligned with the pipeline.
// Depends on nothing else.
`default_nettype none
module scae_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr_r [0:N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];
endmodule
`default_nettype wire

[rtl/scae_log2.sv]
// Pipelined base-2 logarithm: integer part plus 32 fraction bits by repeated squaring.
// Each squaring takes two stages (partial products, then sum). Depends on scae_pkg.
`default_nettype none
module scae_log2 #(
  parameter int W = 48
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [W-1:0]                              x,
  output logic [$clog2(W)+scae_pkg::LOG_ITER-1:0]   y
);
  import scae_pkg::*;
  localparam int NW = $clog2(W);

  logic [NW-1:0] n_enc;
  logic [W-1:0]  x_r;
  logic [NW-1:0] ne_r;

  logic [63:0]         m_r [0:LOG_ITER];
  logic [LOG_ITER-1:0] f_r [0:LOG_ITER];
  logic [NW-1:0]       n_r [0:LOG_ITER];

  // Leading-one position; zero input gives zero, and the result is then zero too.
  always_comb begin
    n_enc = '0;
    for (int i = 0; i < W; i++) begin
      if (x[i]) n_enc = NW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x;
      ne_r   <= n_enc;
      m_r[0] <= 64'(x_r) << (7'd62 - 7'(ne_r));
      f_r[0] <= '0;
      n_r[0] <= ne_r;
    end
  end

  for (genvar i = 0; i < LOG_ITER; i++) begin : g_iter
    logic [63:0]         ll_r, lm_r, hh_r;
    logic [LOG_ITER-1:0] fa_r;
    logic [NW-1:0]       na_r;
    logic [127:0]        sq;
    logic [63:0]         mq;

    always_ff @(posedge clk) begin
      if (en) begin
        ll_r <= 64'(m_r[i][31:0]) * 64'(m_r[i][31:0]);
        lm_r <= 64'(m_r[i][31:0]) * 64'(m_r[i][63:32]);
        hh_r <= 64'(m_r[i][63:32]) * 64'(m_r[i][63:32]);
        fa_r <= f_r[i];
        na_r <= n_r[i];
      end
    end

    always_comb begin
      sq = {hh_r, 64'd0} + ({64'd0, lm_r} << 33) + {64'd0, ll_r};
      mq = sq[125:62];
    end

    // A square of 2 or more yields a one bit and renormalizes the mantissa.
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[i+1] <= mq[63] ? (mq >> 1) : mq;
        f_r[i+1] <= {fa_r[LOG_ITER-2:0], mq[63]};
        n_r[i+1] <= na_r;
      end
    end
  end

  assign y = {n_r[LOG_ITER], f_r[LOG_ITER]};
endmodule
`default_nettype wire

[rtl/scae_recip.sv]
// Pipelined restoring divider for u = floor(2^64 / d) mod 2^64, one quotient bit a stage.
// Depends on scae_pkg.
`default_nettype none
module scae_recip (
  input  logic                      clk,
  input  logic                      en,
  input  logic [scae_pkg::LR_W-1:0] d,
  output logic [63:0]               q
);
  import scae_pkg::*;

  logic [LR_W-1:0] r_r [0:DIV_STEPS-1];
  logic [63:0]     q_r [0:DIV_STEPS-1];
  logic [LR_W-1:0] d_r [0:DIV_STEPS-1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [LR_W-1:0] r_in, d_in;
    logic [63:0]     q_in;
    logic [LR_W:0]   t;
    logic            ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign d_in = d;
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign q_in = q_r[k-1];
      assign d_in = d_r[k-1];
    end

    // The numerator is a single one followed by 64 zeros.
    assign t  = {r_in, (k == 0) ? 1'b1 : 1'b0};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= ge ? LR_W'(t - {1'b0, d_in}) : t[LR_W-1:0];
        q_r[k] <= {q_in[62:0], ge};
        d_r[k] <= d_in;
      end
    end
  end

  assign q = q_r[DIV_STEPS-1];
endmodule
`default_nettype wire

[rtl/scae_ln2mul.sv]
// Two-stage multiply of a magnitude by ln 2 (Q0.64), keeping the product bits above bit 63, with sign.
// Depends on scae_pkg.
`default_nettype none
module scae_ln2mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [scae_pkg::LR_W-1:0] mag,
  input  logic                      neg,
  output logic signed [63:0]        p
);
  import scae_pkg::*;
  localparam int PW = LR_W + 32;

  logic [PW-1:0]      ph_r, pl_r;
  logic               neg_r;
  logic [LR_W+63:0]   sum;
  logic [LR_W-1:0]    h;
  logic signed [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r  <= PW'(mag) * PW'(LN2_Q64[63:32]);
      pl_r  <= PW'(mag) * PW'(LN2_Q64[31:0]);
      neg_r <= neg;
    end
  end

  assign sum = {ph_r, 32'd0} + {32'd0, pl_r};
  assign h   = sum[LR_W+63:64];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? (64'd0 - 64'(h)) : 64'(h);
    end
  end

  assign p = p_r;
endmodule
`default_nettype wire

[rtl/scae_smul.sv]
// Two-stage Q.32 sign-magnitude multiply, truncated toward zero, magnitude capped at 2^61.
// Depends on scae_pkg.
`default_nettype none
module scae_smul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);
  import scae_pkg::*;

  logic [63:0]        ma, mb;
  logic [63:0]        ll_r, lh_r, hl_r, hh_r;
  logic               neg_r;
  logic [127:0]       sum;
  logic [63:0]        r;
  logic signed [63:0] p_r;

  assign ma = a[63] ? (64'd0 - a) : a;
  assign mb = b[63] ? (64'd0 - b) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= 64'(ma[31:0]) * 64'(mb[31:0]);
      lh_r  <= 64'(ma[31:0]) * 64'(mb[63:32]);
      hl_r  <= 64'(ma[63:32]) * 64'(mb[31:0]);
      hh_r  <= 64'(ma[63:32]) * 64'(mb[63:32]);
      neg_r <= a[63] ^ b[63];
    end
  end

  // Below 2^93 the shifted product is at most 2^61 - 1, so one test covers both limits.
  assign sum = {hh_r, 64'd0} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {64'd0, ll_r};
  assign r   = (|sum[127:93]) ? SAT_LIM : sum[95:32];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? (64'd0 - r) : r;
    end
  end

  assign p = p_r;
endmodule
`default_nettype wire

[rtl/strong_coupling_analytic_eval.sv]
// Strong coupling evaluator top level: flavour selection, logarithms, reciprocal and series.
// Depends on scae_pkg, scae_delay, scae_log2, scae_recip, scae_ln2mul and scae_smul.
//
// One energy scale enters per clock and one alpha_s result leaves per clock while the
// output is not back-pressured. The pipeline consists of two chained 32-step squaring
// logarithm pipelines (one for ln(q2/lambda_sq), one for ln L), each squaring spread
// over two stages, plus the 65-stage reciprocal that runs beside the second logarithm
// and five chained two-stage multiplies of the series. The whole pipeline holds on
// output backpressure only when its last stage and the output register are both full,
// so bubbles are squeezed out. Configuration must be written while idle.
`default_nettype none
module strong_coupling_analytic_eval (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [scae_pkg::Q2_W-1:0]    in_tdata,   // [47:0] q2
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata,  // [31:0] alpha_s, [34:32] active_flavours
  output logic                         out_tuser,  // [0] domain_error
  input  logic                         cfg_wr_en,
  input  logic [0:0]                   cfg_index,
  input  logic [scae_pkg::LAM_W-1:0]   cfg_wdata
);
  import scae_pkg::*;

  localparam int LQ_W  = $clog2(Q2_W) + LOG_ITER;
  localparam int LL_W  = $clog2(LAM_W) + LOG_ITER;
  localparam int LR2_W = $clog2(LR_W) + LOG_ITER;
  localparam int T_LR  = LOG_LAT + 1 + LN2_LAT;
  localparam int T3    = T_LR + LOG_LAT + LN2_LAT;
  localparam int U_PAD = LOG_LAT + LN2_LAT - DIV_STEPS;
  localparam int T_END = T3 + 5 * SMUL_LAT;

  logic [LAM_W-1:0] lambda_r;
  logic [ORD_W-1:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r <= LAMBDA_RST;
      order_r  <= ORDER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LAMBDA_SQ: lambda_r <= cfg_wdata;
        REG_EXP_ORDER: order_r  <= cfg_wdata[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side: flavour count, domain check and the effective settings.
  logic [LAM_W-1:0] lam_eff;
  side_t            side_in;
  logic             en, v_end, out_load;

  always_comb begin
    lam_eff = (lambda_r == '0) ? LAM_W'(1) : lambda_r;
    if (in_tdata < NF3_MIN)      side_in.nf = 3'd2;
    else if (in_tdata < NF4_MIN) side_in.nf = 3'd3;
    else if (in_tdata < NF5_MIN) side_in.nf = 3'd4;
    else if (in_tdata < NF6_MIN) side_in.nf = 3'd5;
    else                         side_in.nf = 3'd6;
    side_in.dom = (in_tdata <= Q2_W'(lam_eff));
    side_in.ord = (order_r == 2'd3) ? 2'd2 : order_r;
  end

  assign en        = !v_end || !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_load  = v_end && (!out_tvalid || out_tready);

  logic             s0_v_r;
  logic [Q2_W-1:0]  q_r;
  logic [LAM_W-1:0] lam_r;
  side_t            side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= in_tdata;
      lam_r  <= lam_eff;
      side_r <= side_in;
    end
  end

  // L2 = log2(q2) - log2(lambda_sq), then L = L2 * ln 2.
  logic [LQ_W-1:0]    lq;
  logic [LL_W-1:0]    llam;
  logic signed [63:0] l2_diff;
  logic [LR_W-1:0]    l2_nxt, l2_r;
  logic signed [63:0] lr_s;
  logic [LR_W-1:0]    lr_fix;

  scae_log2 #(.W(Q2_W)) u_log_q (.clk(clk), .en(en), .x(q_r), .y(lq));
  scae_log2 #(.W(LAM_W)) u_log_lam (.clk(clk), .en(en), .x(lam_r), .y(llam));

  assign l2_diff = $signed(64'(lq)) - $signed(64'(llam));
  assign l2_nxt  = (l2_diff < 64'sd1) ? LR_W'(1) : l2_diff[LR_W-1:0];

  always_ff @(posedge clk) begin
    if (en) l2_r <= l2_nxt;
  end

  scae_ln2mul u_ln2_l (.clk(clk), .en(en), .mag(l2_r), .neg(1'b0), .p(lr_s));

  assign lr_fix = (lr_s[LR_W-1:0] == '0) ? LR_W'(1) : lr_s[LR_W-1:0];

  // u = 1/L beside l = ln L.
  logic [63:0]        u_raw, u0, u2, u4, u6;
  logic [LR2_W-1:0]   llr;
  logic signed [63:0] ll2, ll;
  logic [LR_W-1:0]    ll2_mag;

  scae_recip u_recip (.clk(clk), .en(en), .d(lr_fix), .q(u_raw));
  scae_log2 #(.W(LR_W)) u_log_lr (.clk(clk), .en(en), .x(lr_fix), .y(llr));

  assign ll2     = $signed(64'(llr)) - LOG_BIAS;
  assign ll2_mag = ll2[63] ? LR_W'(64'd0 - ll2) : ll2[LR_W-1:0];

  scae_ln2mul u_ln2_ll (.clk(clk), .en(en), .mag(ll2_mag), .neg(ll2[63]), .p(ll));

  scae_delay #(.W(64), .N(U_PAD)) u_dly_u0 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(u_raw), .q(u0));
  scae_delay #(.W(64), .N(SMUL_LAT)) u_dly_u2 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(u0), .q(u2));
  scae_delay #(.W(64), .N(SMUL_LAT)) u_dly_u4 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(u2), .q(u4));
  scae_delay #(.W(64), .N(SMUL_LAT)) u_dly_u6 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(u4), .q(u6));

  side_t side_a, side_b, side_c, side_d;

  scae_delay #(.W($bits(side_t)), .N(T3)) u_dly_sa (
    .clk(clk), .rst_n(rst_n), .en(en), .d(side_r), .q(side_a));
  scae_delay #(.W($bits(side_t)), .N(SMUL_LAT)) u_dly_sb (
    .clk(clk), .rst_n(rst_n), .en(en), .d(side_a), .q(side_b));
  scae_delay #(.W($bits(side_t)), .N(3 * SMUL_LAT)) u_dly_sc (
    .clk(clk), .rst_n(rst_n), .en(en), .d(side_b), .q(side_c));
  scae_delay #(.W($bits(side_t)), .N(SMUL_LAT)) u_dly_sd (
    .clk(clk), .rst_n(rst_n), .en(en), .d(side_c), .q(side_d));
  scae_delay #(.W(1), .N(T_END)) u_dly_v (
    .clk(clk), .rst_n(rst_n), .en(en), .d(s0_v_r), .q(v_end));

  // Series: alpha = (A u) * (1 - c1 l u + ((l - 1/2)^2 + d) c1^2 u^2), terms gated by order.
  logic signed [63:0] dl, x1, y1, z1, x2, yd, y2, y3, y4, x2d, zd, tmp, alpha;

  assign dl = ll - HALF_Q32;

  scae_smul u_mul_x1 (.clk(clk), .en(en), .a(coef_c1(side_a.nf)), .b(ll), .p(x1));
  scae_smul u_mul_y1 (.clk(clk), .en(en), .a(dl), .b(dl), .p(y1));
  scae_smul u_mul_z1 (.clk(clk), .en(en), .a(coef_a(side_a.nf)), .b($signed(u0)), .p(z1));

  assign yd = y1 + coef_d(side_b.nf);

  scae_smul u_mul_x2 (.clk(clk), .en(en), .a(x1), .b($signed(u2)), .p(x2));
  scae_smul u_mul_y2 (.clk(clk), .en(en), .a(yd), .b(coef_cc(side_b.nf)), .p(y2));
  scae_smul u_mul_y3 (.clk(clk), .en(en), .a(y2), .b($signed(u4)), .p(y3));
  scae_smul u_mul_y4 (.clk(clk), .en(en), .a(y3), .b($signed(u6)), .p(y4));

  scae_delay #(.W(64), .N(2 * SMUL_LAT)) u_dly_x2 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(x2), .q(x2d));
  scae_delay #(.W(64), .N(3 * SMUL_LAT)) u_dly_z (
    .clk(clk), .rst_n(rst_n), .en(en), .d(z1), .q(zd));

  assign tmp = ONE_Q32 - ((side_c.ord >= 2'd1) ? x2d : 64'sd0)
                       + ((side_c.ord >= 2'd2) ? y4 : 64'sd0);

  scae_smul u_mul_alpha (.clk(clk), .en(en), .a(zd), .b(tmp), .p(alpha));

  // Q.32 to Q4.28 by a magnitude shift, then clamp to the 32-bit range.
  logic [63:0]        alpha_mag;
  logic [59:0]        am;
  logic [ALPHA_W-1:0] res_nxt, res_r;
  logic [NF_W-1:0]    nf_r;
  logic               dom_r;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    alpha_mag = alpha[63] ? (64'd0 - alpha) : alpha;
    am        = alpha_mag[63:4];
    if (side_d.dom) begin
      res_nxt = '0;
    end else if (alpha[63]) begin
      res_nxt = (am >= 60'h0_0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - am[31:0]);
    end else begin
      res_nxt = (am > 60'h0_0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : am[31:0];
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
      nf_r  <= side_d.nf;
      dom_r <= side_d.dom;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, nf_r, res_r};
  assign out_tuser  = dom_r;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  a_domain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[31:0] == 32'd0))
    else $error("domain error result carries a nonzero coupling");

  a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:32] >= 3'd2 && out_tdata[34:32] <= 3'd6))
    else $error("flavour count out of range");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("loaded result not presented");
`endif
endmodule
`default_nettype wire

[verif/testbench.sv]
// Testbench for the strong coupling evaluator: drives energy scales over the input stream,
// predicts alpha_s, flavour count and domain flag bit for bit, and checks every result.
// Depends on scae_pkg and strong_coupling_analytic_eval.
`timescale 1ns / 100ps
module testbench;
  import scae_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [Q2_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [39:0]         out_tdata;
  logic                out_tuser;
  logic                cfg_wr_en = 1'b0;
  logic [0:0]          cfg_index = REG_LAMBDA_SQ;
  logic [LAM_W-1:0]    cfg_wdata = '0;

  strong_coupling_analytic_eval DUT (.*);

  initial forever #1 clk = ~clk;

  typedef struct {
    logic [ALPHA_W-1:0] alpha;
    logic [NF_W-1:0]    nf;
    logic               dom;
  } coupling_t;

  coupling_t        pending_q[$];
  logic [LAM_W-1:0] lam_reg = LAMBDA_RST;
  logic [ORD_W-1:0] ord_reg = ORDER_RST;
  int               errors = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_cycles = 0;
  longint           cycle_cnt = 0;

  // 64x64 -> 128 bit unsigned product.
  function automatic logic [127:0] umul(input logic [63:0] a, input logic [63:0] b);
    umul = {64'd0, a} * {64'd0, b};
  endfunction

  function automatic logic signed [63:0] log2_fix(input logic [63:0] x);
    logic [63:0] m, f;
    logic [127:0] p;
    int n;
    f = 0;
    if (x == 0) return 0;
    n = 63;
    while (x[n] == 1'b0) n--;
    m = (n <= 62) ? (x << (62 - n)) : (x >> 1);
    for (int i = 0; i < 32; i++) begin
      p = umul(m, m);
      m = p[125:62];
      f = f << 1;
      if (m[63]) begin
        f[0] = 1'b1;
        m = m >> 1;
      end
    end
    log2_fix = $signed(({32'd0, 32'(n)} << 32) | f);
  endfunction

  function automatic logic [63:0] mul_ln2(input logic [63:0] m);
    logic [127:0] p;
    p = umul(m, LN2_Q64);
    mul_ln2 = p[127:64];
  endfunction

  function automatic logic [63:0] magn(input logic signed [63:0] a);
    magn = a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0] r;
    p = umul(magn(a), magn(b));
    if (p[127:64] >= (64'd1 << 29)) r = SAT_LIM;
    else r = p[95:32];
    if (r > SAT_LIM) r = SAT_LIM;
    qmul = (a[63] != b[63]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic coupling_t predict_coupling(input logic [Q2_W-1:0] q);
    coupling_t res;
    logic [63:0] lam, lr, qd, rem, am;
    logic signed [63:0] nf, n0, n1, n2, a, c1, d, l2, ll2, ll, u, t, alpha, dl, p;
    logic [1:0] ord;
    lam = (lam_reg == 0) ? 64'd1 : {40'd0, lam_reg};
    if (q < 656) nf = 2;
    else if (q < 109059) nf = 3;
    else if (q < 1101661) nf = 4;
    else if (q < 48'd1938817024) nf = 5;
    else nf = 6;
    res.nf = nf[2:0];
    res.alpha = '0;
    res.dom = 1'b1;
    if ({16'd0, q} <= lam) return res;
    res.dom = 1'b0;
    n0 = 33 - 2 * nf;
    n1 = 153 - 19 * nf;
    n2 = 77139 - 15099 * nf + 325 * nf * nf;
    a = $signed(((64'd12 * 64'h0324_3F6A_8885_A309) / n0) >> 24);
    c1 = $signed((64'(6 * n1) << 32) / 64'(n0 * n0));
    d = (n2 * n0 * 64'sh1_0000_0000) / (72 * n1 * n1) - 5 * (64'sd1 <<< 30);
    l2 = log2_fix({16'd0, q}) - log2_fix(lam);
    if (l2 < 1) l2 = 1;
    lr = mul_ln2(l2);
    if (lr == 0) lr = 1;
    qd = 64'hFFFF_FFFF_FFFF_FFFF / lr;
    rem = 64'hFFFF_FFFF_FFFF_FFFF - qd * lr;
    if (rem == lr - 1) qd++;
    u = $signed(qd);
    ll2 = log2_fix(lr) - (64'sd32 <<< 32);
    ll = $signed(mul_ln2(magn(ll2)));
    if (ll2 < 0) ll = -ll;
    ord = (ord_reg > 2) ? 2'd2 : ord_reg;
    t = 64'sh1_0000_0000;
    if (ord >= 1) t -= qmul(qmul(c1, ll), u);
    if (ord >= 2) begin
      dl = ll - 64'sh8000_0000;
      p = qmul(qmul(dl, dl) + d, qmul(c1, c1));
      t += qmul(qmul(p, u), u);
    end
    alpha = qmul(qmul(a, u), t);
    am = magn(alpha) >> 4;
    if (alpha < 0) begin
      if (am > 64'h8000_0000) am = 64'h8000_0000;
      res.alpha = 32'(-$signed(am));
    end else begin
      if (am > 64'h7FFF_FFFF) am = 64'h7FFF_FFFF;
      res.alpha = am[31:0];
    end
    return res;
  endfunction

  // The valid line stays high between back-to-back transfers and drops only while idling.
  task automatic send_scale(input logic [Q2_W-1:0] q);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    do @(posedge clk); while (!in_tready);
    pending_q = {pending_q, predict_coupling(q)};
  endtask

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    coupling_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_tdata[31:0] !== exp_r.alpha) begin
          $error("alpha_s expected %h actual %h", exp_r.alpha, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[34:32] !== exp_r.nf) begin
          $error("active_flavours expected %0d actual %0d", exp_r.nf, out_tdata[34:32]);
          errors++;
        end
        if (out_tuser !== exp_r.dom) begin
          $error("domain_error expected %0d actual %0d", exp_r.dom, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk)
    if (cycle_cnt > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [LAM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_LAMBDA_SQ) lam_reg = val;
    else ord_reg = val[ORD_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic [Q2_W-1:0] rand_scale();
    logic [Q2_W-1:0] q;
    int sel;
    sel = $urandom_range(9);
    q = Q2_W'({$urandom, $urandom});
    case (sel)
      0: q = q >> $urandom_range(47);
      1: q = {24'd0, lam_reg} + Q2_W'($urandom_range(3)) - 48'd1;
      2: q = NF3_MIN - 48'd1 + Q2_W'($urandom_range(2));
      3: q = NF4_MIN - 48'd1 + Q2_W'($urandom_range(2));
      4: q = NF5_MIN - 48'd1 + Q2_W'($urandom_range(2));
      5: q = NF6_MIN - 48'd1 + Q2_W'($urandom_range(2));
      default: q = q >> $urandom_range(30);
    endcase
    return q;
  endfunction

  task automatic test_directed();
    logic [Q2_W-1:0] pts[$];
    pts = '{48'd0, 48'd1, 48'd655, 48'd656, 48'd26214, 48'd26215, 48'd26300,
            48'd109058, 48'd109059, 48'd1101660, 48'd1101661, 48'd1938817023,
            48'd1938817024, {Q2_W{1'b1}}, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
            48'd40000, 48'd655360000};
    foreach (pts[i]) send_scale(pts[i]);
    wait_drain();
    write_reg(REG_LAMBDA_SQ, 24'd0);   // zero lambda acts as one LSB
    send_scale(48'd1); send_scale(48'd2); send_scale(48'd3); send_scale(48'd1000);
    wait_drain();
    write_reg(REG_EXP_ORDER, 24'd3);   // order three behaves as order two
    write_reg(REG_LAMBDA_SQ, {LAM_W{1'b1}});
    send_scale(48'd16777216); send_scale(48'd16777300); send_scale({Q2_W{1'b1}});
    wait_drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        wait_drain();
        write_reg(REG_LAMBDA_SQ, LAM_W'(($urandom_range(3) == 0) ?
                  $urandom_range(LAM_W - 1) + 1 : $urandom >> ($urandom_range(23) + 8)));
        write_reg(REG_EXP_ORDER, LAM_W'($urandom_range(3)));
      end
      send_scale(rand_scale());
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 200; i++) send_scale(rand_scale());
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(150);
    send_idle_pct = 59; recv_stall_pct = 0;  test_random(150);
    send_idle_pct = 0;  recv_stall_pct = 59; test_random(150);
    send_idle_pct = 15; recv_stall_pct = 15; test_random(150);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
